// File: src/phsr_pkg.sv
// Package for the four-stage allpass phaser: sample and coefficient types,
// fixed-point widths, and the rounding and saturation helpers.
// No dependencies.
`default_nettype none

package phsr_pkg;

  localparam int SAMPLE_W = 24;            // Q4.20 samples and state
  localparam int COEF_W   = 18;
  localparam int CF_BITS  = COEF_W - 1;    // coefficient field width
  localparam int CF_FRAC  = COEF_W - 2;    // coefficient fraction bits
  localparam int NUM_SECT = 4;
  localparam int SECT_W   = $clog2(NUM_SECT);
  localparam int DIFF_W   = SAMPLE_W + 1;  // exact section difference
  localparam int PROD_W   = CF_BITS + DIFF_W;
  localparam int RND_W    = PROD_W - CF_FRAC;
  localparam int SUM_W    = RND_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [CF_BITS-1:0]  coef_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [RND_W-1:0]    rnd_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Round half toward +infinity, then drop the coefficient fraction bits.
  function automatic rnd_t round_prod(input prod_t p);
    prod_t q;
    q = p + PROD_W'(1 << (CF_FRAC - 1));
    return q[PROD_W-1:CF_FRAC];
  endfunction

  // Clamp a wide sum to the signed sample range.
  function automatic sample_t sat_sample(input sum_t v);
    sample_t r;
    if (v[SUM_W-1:SAMPLE_W-1] == '0 || v[SUM_W-1:SAMPLE_W-1] == '1) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/four_stage_allpass_phaser.sv
// Four-stage allpass phaser top level: feedback sum and four first-order
// allpass sections computed on one shared multiplier.
// Depends on phsr_pkg.
`default_nettype none

// One sample is processed at a time. The transaction is captured, the
// feedback product is formed and summed, each allpass section then takes a
// difference, multiply, and round and add step, and the result is presented,
// all paced by the single 17x25-bit multiplier that every product goes
// through. The input is stalled from acceptance until the result transaction
// completes. Section state resets to zero.
module four_stage_allpass_phaser (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire phsr_pkg::sample_t  in_sample_in,
  input  wire phsr_pkg::coef_t    in_feedback_gain,
  input  wire phsr_pkg::coef_t    in_coef_one,
  input  wire phsr_pkg::coef_t    in_coef_two,
  input  wire phsr_pkg::coef_t    in_coef_three,
  input  wire phsr_pkg::coef_t    in_coef_four,
  output logic                    out_valid,
  input  wire                     out_stall,
  output phsr_pkg::sample_t       out_sample_out
);
  import phsr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB_MUL,
    ST_FB_ADD,
    ST_DIFF,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t            state_r;
  logic [SECT_W-1:0] sect_r;
  logic              out_valid_r;
  sample_t           out_sample_r;

  sample_t           sample_r;
  coef_t             gain_r;
  coef_t             coef_r     [NUM_SECT];
  sample_t           prev_in_r  [NUM_SECT];
  sample_t           prev_out_r [NUM_SECT];
  sample_t           x_r;
  diff_t             diff_r;
  prod_t             prod_r;

  coef_t             mul_a;
  diff_t             mul_b;
  prod_t             prod_nxt;
  sample_t           fb_nxt;
  sample_t           y_nxt;
  diff_t             diff_nxt;

  // Shared multiplier: feedback gain times last output, or the current
  // section's coefficient times its difference.
  always_comb begin
    if (state_r == ST_FB_MUL) begin
      mul_a = gain_r;
      mul_b = DIFF_W'(prev_out_r[NUM_SECT-1]);
    end else begin
      mul_a = coef_r[sect_r];
      mul_b = diff_r;
    end
    prod_nxt = mul_a * mul_b;
  end

  assign fb_nxt   = sat_sample(SUM_W'(sample_r) + SUM_W'(round_prod(prod_r)));
  assign y_nxt    = sat_sample(SUM_W'(round_prod(prod_r)) + SUM_W'(prev_in_r[sect_r]));
  assign diff_nxt = DIFF_W'(x_r) - DIFF_W'(prev_out_r[sect_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sect_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SECT; i++) begin
        prev_in_r[i]  <= '0;
        prev_out_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sample_r  <= in_sample_in;
            gain_r    <= in_feedback_gain;
            coef_r[0] <= in_coef_one;
            coef_r[1] <= in_coef_two;
            coef_r[2] <= in_coef_three;
            coef_r[3] <= in_coef_four;
            sect_r    <= '0;
            state_r   <= ST_FB_MUL;
          end
        end
        ST_FB_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_FB_ADD;
        end
        ST_FB_ADD: begin
          x_r     <= fb_nxt;
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_r  <= diff_nxt;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          prev_in_r[sect_r]  <= x_r;
          prev_out_r[sect_r] <= y_nxt;
          x_r                <= y_nxt;
          if (sect_r == SECT_W'(NUM_SECT - 1)) begin
            out_sample_r <= y_nxt;
            out_valid_r  <= 1'b1;
            sect_r       <= '0;
            state_r      <= ST_OUT;
          end else begin
            sect_r  <= sect_r + 1'b1;
            state_r <= ST_DIFF;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

`ifndef ASSERT_OFF
  // A finished result must hold off new input until it is taken.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // An accepted transaction starts processing on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("block not busy after accepting a transaction");

  // The section counter is parked at zero whenever the block is idle.
  a_idle_sect: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (sect_r == '0))
    else $error("section counter not cleared while idle");

  // A result appears only right after the last section's add step.
  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_ADD))
    else $error("result raised outside the last section step");
`endif

endmodule

`default_nettype wire
